// ----- rtl/tcf_pkg.sv -----
// Shared types, protocol codes and handshake structs for the telnet command filter.
// No dependencies; every other file of the block but tcf_ram imports this package.
package tcf_pkg;

  // Default number of subnegotiation bytes the store can hold.
  localparam int SUB_DEPTH_DEF = 64;

  // Number of leading store bytes that are mirrored in flip-flops.
  localparam int SHADOW_N = 5;

  // Packed widths of the stream payloads.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;

  // Telnet command bytes.
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_AYT  = 8'd246;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_DONT = 8'd254;

  // Telnet option codes.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_DATA = 3'd0,
    PH_CMD  = 3'd1,
    PH_OPT  = 3'd2,
    PH_SUB  = 3'd3,
    PH_PROC = 3'd4
  } phase_t;

  // Kind of a result transaction.
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_SWALLOW = 3'd1,
    KIND_REFUSE  = 3'd2,
    KIND_AYT     = 3'd3,
    KIND_RESIZE  = 3'd4,
    KIND_TTYPE   = 3'd5
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_EMIT = 2'd2
  } ctl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // take the input byte and update the parser
    logic rd_issue;  // read the next terminal-type name byte
    logic emit;      // load the name byte into the output register
  } tcf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;   // output register can be loaded this cycle
    logic start_run;  // the offered byte ends a terminal-type subnegotiation
    logic run_end;    // the name byte being read is the final one
  } tcf_sts_t;

  // Options that the filter is willing to negotiate.
  function automatic logic option_accepted(input logic [7:0] code);
    return (code == OPT_BINARY) || (code == OPT_ECHO) || (code == OPT_SGA) ||
           (code == OPT_TTYPE) || (code == OPT_NAWS);
  endfunction

endpackage

// ----- rtl/telnet_command_filter_unit.sv -----
// Top level of the telnet command filter: stream ports, controller and datapath.
// Depends on tcf_pkg, tcf_ctrl and tcf_datapath (which holds the tcf_ram store).
//
//   Channel  Direction  Transaction carries
//   in_*     slave      one received byte, tlast marks the end of a chunk
//   out_*    master     one result; tuser is its kind, tlast the final result of a byte
//
// Every received byte is taken while the output register is free or being
// drained, and yields one result. A terminal-type end of subnegotiation with
// N stored bytes yields N-2 name bytes instead, each read from the store's
// registered port, and the input stalls meanwhile. Reset is synchronous and
// active low; the store needs no clearing pass, so the block takes bytes right
// after reset. A stall on the output side holds the result register and,
// through it, the input.
module telnet_command_filter_unit
  import tcf_pkg::*;
#(
  parameter int SUB_DEPTH = SUB_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic                   in_tlast,   // end_of_chunk
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [8] refuse_with_wont,
                                             // [16:9] refused_option, [32:17] window_width,
                                             // [48:33] window_height,
                                             // [49] chunk_all_swallowed, [55:50] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [2:0] kind
  output logic                   out_tlast   // run_last
);

  tcf_cmd_t    cmd;
  tcf_sts_t    sts;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_wont;
  logic [7:0]  res_opt;
  logic [15:0] res_width;
  logic [15:0] res_height;
  logic        res_all;

  // The controller only decides when to take a byte and when to step the
  // name run; all parsing state sits in the datapath.
  tcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcf_datapath #(
    .SUB_DEPTH (SUB_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_tdata[7:0]),
    .end_of_chunk (in_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (res_kind),
    .out_byte     (res_byte),
    .out_wont     (res_wont),
    .out_opt      (res_opt),
    .out_width    (res_width),
    .out_height   (res_height),
    .out_last     (out_tlast),
    .out_all      (res_all)
  );

  // Pack the result fields from the lowest bit up, zero-padded to whole bytes.
  assign out_tdata = {6'd0, res_all, res_height, res_width, res_opt, res_wont, res_byte};
  assign out_tuser = res_kind;

endmodule

// ----- rtl/tcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tcf_datapath.sv -----
// Datapath of the telnet command filter: parser registers, subnegotiation store,
// name-byte read index and the output register. Depends on tcf_pkg and tcf_ram.
module tcf_datapath
  import tcf_pkg::*;
#(
  parameter int SUB_DEPTH = SUB_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             rx_byte,
  input  logic                   end_of_chunk,
  input  tcf_cmd_t               cmd,
  output tcf_sts_t               sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output kind_t                  out_kind,
  output logic [7:0]             out_byte,
  output logic                   out_wont,
  output logic [7:0]             out_opt,
  output logic [15:0]            out_width,
  output logic [15:0]            out_height,
  output logic                   out_last,
  output logic                   out_all
);

  localparam int ADDR_W = $clog2(SUB_DEPTH);
  localparam int CNT_W  = $clog2(SUB_DEPTH + 1);

  // Parser state.
  phase_t             phase_r, phase_nxt;
  logic               esc_r, esc_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               kept_r, kept_nxt;
  logic [7:0]         shadow_r [SHADOW_N];

  // Name-byte run state.
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               run_all_r, run_all_nxt;

  // Output register.
  logic               ovalid_r, ovalid_nxt;
  kind_t              okind_r, okind_nxt;
  logic [7:0]         obyte_r, obyte_nxt;
  logic               owont_r, owont_nxt;
  logic [7:0]         oopt_r, oopt_nxt;
  logic [15:0]        ow_r, ow_nxt;
  logic [15:0]        oh_r, oh_nxt;
  logic               olast_r, olast_nxt;
  logic               oall_r, oall_nxt;

  // Decode of the offered byte.
  phase_t             ph_eff;
  phase_t             dec_phase;
  logic               dec_esc;
  logic [7:0]         dec_pend;
  logic [CNT_W-1:0]   dec_cnt;
  logic               dec_pass;
  logic               dec_store;
  logic               dec_start_run;
  kind_t              dec_kind;
  logic               dec_wont;
  logic [7:0]         dec_opt;
  logic [15:0]        dec_w;
  logic [15:0]        dec_h;
  logic               dec_kept;
  logic               dec_all;

  logic [7:0]         ram_rdata;
  logic               run_end;
  logic               load_acc;

  always_comb begin
    ph_eff        = phase_r;
    dec_phase     = phase_r;
    dec_esc       = esc_r;
    dec_pend      = pend_r;
    dec_cnt       = cnt_r;
    dec_pass      = 1'b0;
    dec_store     = 1'b0;
    dec_start_run = 1'b0;
    dec_kind      = KIND_SWALLOW;
    dec_wont      = 1'b0;
    dec_opt       = '0;
    dec_w         = '0;
    dec_h         = '0;
    if (rx_byte == TN_IAC && !esc_r) begin
      dec_esc = 1'b1;
    end else begin
      if (esc_r) begin
        if (phase_r == PH_DATA) begin
          ph_eff = PH_CMD;
        end else if (phase_r == PH_SUB && rx_byte == TN_SE) begin
          ph_eff = PH_PROC;
        end
        dec_esc = 1'b0;
      end
      case (ph_eff)
        PH_CMD: begin
          dec_phase = PH_DATA;
          if (rx_byte >= TN_WILL && rx_byte <= TN_DONT) begin
            dec_pend  = rx_byte;
            dec_phase = PH_OPT;
          end else if (rx_byte == TN_SB) begin
            dec_phase = PH_SUB;
            dec_cnt   = '0;
          end else if (rx_byte == TN_AYT) begin
            dec_kind = KIND_AYT;
          end
        end
        PH_OPT: begin
          dec_phase = PH_DATA;
          if (!option_accepted(rx_byte) && (pend_r == TN_WILL || pend_r == TN_DO)) begin
            dec_kind = KIND_REFUSE;
            dec_wont = (pend_r == TN_DO);
            dec_opt  = rx_byte;
          end
        end
        PH_SUB: begin
          // The count stays below the depth while in this phase.
          dec_store = 1'b1;
          dec_cnt   = cnt_r + CNT_W'(1);
          if (dec_cnt >= CNT_W'(SUB_DEPTH)) begin
            dec_phase = PH_DATA;
            dec_pass  = 1'b1;
          end
        end
        PH_PROC: begin
          dec_phase = PH_DATA;
          if (shadow_r[0] == OPT_NAWS) begin
            dec_kind = KIND_RESIZE;
            dec_w    = {shadow_r[1], shadow_r[2]};
            dec_h    = {shadow_r[3], shadow_r[4]};
          end else if (shadow_r[0] == OPT_TTYPE && cnt_r > CNT_W'(2)) begin
            dec_start_run = 1'b1;
          end
        end
        default: begin
          dec_phase = PH_DATA;
          dec_pass  = 1'b1;
        end
      endcase
    end
    if (dec_pass) begin
      dec_kind = KIND_DATA;
    end
    dec_kept = kept_r | dec_pass;
    dec_all  = end_of_chunk & ~dec_kept;
  end

  assign run_end  = (CNT_W'(rd_idx_r) == cnt_r - CNT_W'(1));
  assign load_acc = cmd.accept & ~dec_start_run;

  assign sts.out_free  = ~ovalid_r | out_ready;
  assign sts.start_run = dec_start_run;
  assign sts.run_end   = run_end;

  always_comb begin
    phase_nxt   = phase_r;
    esc_nxt     = esc_r;
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    kept_nxt    = kept_r;
    rd_idx_nxt  = rd_idx_r;
    run_all_nxt = run_all_r;
    if (cmd.accept) begin
      phase_nxt = dec_phase;
      esc_nxt   = dec_esc;
      pend_nxt  = dec_pend;
      cnt_nxt   = dec_cnt;
      kept_nxt  = end_of_chunk ? 1'b0 : dec_kept;
      if (dec_start_run) begin
        rd_idx_nxt  = ADDR_W'(2);
        run_all_nxt = dec_all;
      end
    end else if (cmd.emit) begin
      rd_idx_nxt = rd_idx_r + ADDR_W'(1);
    end
  end

  always_comb begin
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    owont_nxt = owont_r;
    oopt_nxt  = oopt_r;
    ow_nxt    = ow_r;
    oh_nxt    = oh_r;
    olast_nxt = olast_r;
    oall_nxt  = oall_r;
    if (load_acc) begin
      okind_nxt = dec_kind;
      obyte_nxt = dec_pass ? rx_byte : 8'd0;
      owont_nxt = dec_wont;
      oopt_nxt  = dec_opt;
      ow_nxt    = dec_w;
      oh_nxt    = dec_h;
      olast_nxt = 1'b1;
      oall_nxt  = dec_all;
    end else if (cmd.emit) begin
      okind_nxt = KIND_TTYPE;
      obyte_nxt = ram_rdata;
      owont_nxt = 1'b0;
      oopt_nxt  = '0;
      ow_nxt    = '0;
      oh_nxt    = '0;
      olast_nxt = run_end;
      oall_nxt  = run_all_r;
    end
    if (load_acc || cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DATA;
      esc_r     <= 1'b0;
      pend_r    <= '0;
      cnt_r     <= '0;
      kept_r    <= 1'b0;
      ovalid_r  <= 1'b0;
      for (int i = 0; i < SHADOW_N; i++) begin
        shadow_r[i] <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      esc_r     <= esc_nxt;
      pend_r    <= pend_nxt;
      cnt_r     <= cnt_nxt;
      kept_r    <= kept_nxt;
      ovalid_r  <= ovalid_nxt;
      if (cmd.accept && dec_store && cnt_r < CNT_W'(SHADOW_N)) begin
        shadow_r[cnt_r[2:0]] <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    run_all_r <= run_all_nxt;
    okind_r   <= okind_nxt;
    obyte_r   <= obyte_nxt;
    owont_r   <= owont_nxt;
    oopt_r    <= oopt_nxt;
    ow_r      <= ow_nxt;
    oh_r      <= oh_nxt;
    olast_r   <= olast_nxt;
    oall_r    <= oall_nxt;
  end

  // Every stored byte that a name run reads was written earlier in the same
  // subnegotiation, so the store needs no clearing.
  tcf_ram #(
    .WIDTH (8),
    .DEPTH (SUB_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept & dec_store),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  assign out_valid  = ovalid_r;
  assign out_kind   = okind_r;
  assign out_byte   = obyte_r;
  assign out_wont   = owont_r;
  assign out_opt    = oopt_r;
  assign out_width  = ow_r;
  assign out_height = oh_r;
  assign out_last   = olast_r;
  assign out_all    = oall_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SUB_DEPTH))
    else $error("subnegotiation count above store depth");

  a_phase_settled: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_CMD && phase_r != PH_PROC)
    else $error("transient parser phase held across a clock");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (rd_idx_r >= ADDR_W'(2) && CNT_W'(rd_idx_r) < cnt_r))
    else $error("name byte read outside the stored bytes");

  a_emit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (ovalid_r && okind_r == KIND_TTYPE && olast_r == $past(run_end)))
    else $error("name byte result not loaded as expected");

endmodule

// ----- rtl/tcf_ctrl.sv -----
// Controller of the telnet command filter: accepts bytes and sequences the
// terminal-type name run through the store. Depends on tcf_pkg.
module tcf_ctrl
  import tcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tcf_sts_t sts,
  output tcf_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid & sts.out_free;
        if (cmd.accept && sts.start_run) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.run_end ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for telnet_command_filter_unit. A behavioral copy of the telnet
// parser predicts every result transaction of each accepted byte and checks the output stream.
// Depends on tcf_pkg and the RTL of the block; needs no files or arguments.
module tb_top;
  import tcf_pkg::*;

  localparam int DEPTH       = SUB_DEPTH_DEF;
  localparam int TOTAL_BYTES = 410;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 20;
  localparam int MAX_REPORTS = 10;

  // Protocol byte that the package does not name.
  localparam logic [7:0] TTYPE_IS  = 8'd0;

  // One result transaction, unpacked into its fields.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic        wont;
    logic [7:0]  opt;
    logic [15:0] cols;
    logic [15:0] rows;
    logic        last_of_byte;
    logic        none_kept;
  } filter_result_t;

  // One received byte waiting to be offered, with the idle time in front of it and
  // a flag that holds it back until every predicted result has been drained.
  typedef struct packed {
    logic [7:0] rx;
    logic       eoc;
    logic       drain;
    logic [7:0] gap;
  } rx_item_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  telnet_command_filter_unit #(
    .SUB_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction. This mirrors the filter's own state: phase, a pending
  // escape, the last negotiation verb, the subnegotiation store and whether the
  // current chunk has passed any data byte yet.
  // ---------------------------------------------------------------------------
  phase_t         flt_phase;
  logic           flt_escape;
  logic [7:0]     flt_verb;
  logic [7:0]     flt_sub_mem [0:DEPTH-1];
  int             flt_sub_len;
  logic           flt_chunk_kept;
  filter_result_t run_buf [0:DEPTH];
  int             run_len;
  filter_result_t pending_results [$];

  int fail_count = 0;
  int kind_seen [0:7];

  function automatic filter_result_t make_result(input kind_t k, input logic [7:0] ch,
                                                 input logic wont, input logic [7:0] opt,
                                                 input logic [15:0] cols,
                                                 input logic [15:0] rows);
    filter_result_t r;
    r          = '0;
    r.kind     = k;
    r.char_out = ch;
    r.wont     = wont;
    r.opt      = opt;
    r.cols     = cols;
    r.rows     = rows;
    return r;
  endfunction

  // Options the far end may switch on without a refusal.
  function automatic logic opt_welcome(input logic [7:0] code);
    case (code)
      OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_TTYPE, OPT_NAWS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_filter_state();
    int i;
    flt_phase      = PH_DATA;
    flt_escape     = 1'b0;
    flt_verb       = 8'd0;
    flt_sub_len    = 0;
    flt_chunk_kept = 1'b0;
    for (i = 0; i < DEPTH; i++) flt_sub_mem[i] = 8'd0;
  endtask

  task automatic push_run(input filter_result_t r);
    run_buf[run_len] = r;
    run_len++;
  endtask

  // Advances the parser by one received byte and queues the results it causes.
  task automatic filter_track_byte(input logic [7:0] c, input logic eoc);
    logic passed;
    int   i;
    passed  = 1'b0;
    run_len = 0;
    if (c == TN_IAC && !flt_escape) begin
      flt_escape = 1'b1;
    end else begin
      // The byte after an escape opens a command from data, and ends a
      // subnegotiation when it is SE. A doubled escape falls through as a byte inside a subnegotiation.
      if (flt_escape) begin
        if (flt_phase == PH_DATA) flt_phase = PH_CMD;
        if (flt_phase == PH_SUB && c == TN_SE) flt_phase = PH_PROC;
        flt_escape = 1'b0;
      end
      case (flt_phase)
        PH_CMD: begin
          flt_phase = PH_DATA;
          if (c >= TN_WILL && c <= TN_DONT) begin
            flt_verb  = c;
            flt_phase = PH_OPT;
          end else if (c == TN_SB) begin
            flt_phase   = PH_SUB;
            flt_sub_len = 0;
          end else if (c == TN_AYT) begin
            push_run(make_result(KIND_AYT, 8'd0, 1'b0, 8'd0, 16'd0, 16'd0));
          end
        end
        PH_OPT: begin
          flt_phase = PH_DATA;
          // Only WILL and DO ask for a reply; WONT and DONT are simply dropped.
          if (!opt_welcome(c) && (flt_verb == TN_WILL || flt_verb == TN_DO))
            push_run(make_result(KIND_REFUSE, 8'd0, flt_verb == TN_DO, c, 16'd0, 16'd0));
        end
        PH_SUB: begin
          if (flt_sub_len < DEPTH) begin
            flt_sub_mem[flt_sub_len] = c;
            flt_sub_len++;
          end
          // A full store gives up on the subnegotiation and lets the byte through.
          if (flt_sub_len >= DEPTH) begin
            flt_phase = PH_DATA;
            passed    = 1'b1;
          end
        end
        PH_PROC: begin
          flt_phase = PH_DATA;
          // Stale store bytes are read as they stand when the window size is short.
          if (flt_sub_mem[0] == OPT_NAWS) begin
            push_run(make_result(KIND_RESIZE, 8'd0, 1'b0, 8'd0,
                                 {flt_sub_mem[1], flt_sub_mem[2]},
                                 {flt_sub_mem[3], flt_sub_mem[4]}));
          end else if (flt_sub_mem[0] == OPT_TTYPE && flt_sub_len > 2) begin
            for (i = 2; i < flt_sub_len; i++)
              push_run(make_result(KIND_TTYPE, flt_sub_mem[i], 1'b0, 8'd0, 16'd0, 16'd0));
          end
        end
        default: begin
          flt_phase = PH_DATA;
          passed    = 1'b1;
        end
      endcase
    end

    if (run_len == 0) begin
      if (passed) push_run(make_result(KIND_DATA, c, 1'b0, 8'd0, 16'd0, 16'd0));
      else push_run(make_result(KIND_SWALLOW, 8'd0, 1'b0, 8'd0, 16'd0, 16'd0));
    end
    if (passed) flt_chunk_kept = 1'b1;
    run_buf[run_len-1].last_of_byte = 1'b1;
    for (i = 0; i < run_len; i++) begin
      if (eoc) run_buf[i].none_kept = !flt_chunk_kept;
      pending_results.push_back(run_buf[i]);
    end
    if (eoc) flt_chunk_kept = 1'b0;
  endtask

  task automatic record_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building. Every byte is queued with its chunk flag and the idle
  // gap in front of it, so the driver only replays the backlog.
  // ---------------------------------------------------------------------------
  rx_item_t rx_backlog [$];
  logic     calm_in    = 1'b0;
  logic     drain_next = 1'b0;

  // Idle lengths: mostly short, now and then a long pause.
  function automatic logic [7:0] pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(1, 3));
    if (r < 95) return 8'($urandom_range(4, 10));
    return 8'($urandom_range(20, 40));
  endfunction

  task automatic put_byte(input logic [7:0] b);
    rx_item_t it;
    // Flip between idle-free stretches and gappy ones every few dozen bytes.
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    it.rx      = b;
    it.eoc     = ($urandom_range(0, 4) == 0);
    it.drain   = drain_next;
    drain_next = 1'b0;
    it.gap     = (calm_in || $urandom_range(0, 99) < 60) ? 8'd0 : pick_pause();
    rx_backlog.push_back(it);
  endtask

  // A literal 255 inside a command or subnegotiation has to be doubled.
  task automatic put_escaped(input logic [7:0] b);
    if (b == TN_IAC) put_byte(TN_IAC);
    put_byte(b);
  endtask

  task automatic put_cmd(input logic [7:0] verb, input logic [7:0] opt);
    put_byte(TN_IAC);
    put_byte(verb);
    put_escaped(opt);
  endtask

  task automatic put_sb_open(input logic [7:0] opt);
    put_byte(TN_IAC);
    put_byte(TN_SB);
    put_escaped(opt);
  endtask

  task automatic put_sb_close();
    put_byte(TN_IAC);
    put_byte(TN_SE);
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 9))
      0: return OPT_BINARY;
      1: return OPT_ECHO;
      2: return OPT_SGA;
      3: return OPT_TTYPE;
      4: return OPT_NAWS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(33, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. It replays the backlog, honoring each byte's gap and drain
  // flag, and feeds the predictor on every accepted input transaction.
  // ---------------------------------------------------------------------------
  rx_item_t next_item;
  logic     have_next  = 1'b0;
  int       gap_left   = 0;
  logic     took;
  logic     drained    = 1'b1;
  int       bytes_sent = 0;

  // Sampled away from the rising edge so the driver sees a settled value.
  always @(negedge clk) drained = (pending_results.size() == 0);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_filter_state();
    end else begin
      took = in_tvalid && in_tready;
      if (took) begin
        filter_track_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (took || !in_tvalid) begin
        if (!have_next && rx_backlog.size() > 0) begin
          next_item = rx_backlog.pop_front();
          have_next = 1'b1;
          gap_left  = next_item.gap;
        end
        if (have_next && gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (have_next && next_item.drain && (took || !drained)) begin
          // Hold the sender back until the block has delivered every result.
          in_tvalid <= 1'b0;
        end else if (have_next) begin
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.rx;
          in_tlast  <= next_item.eoc;
          have_next = 1'b0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure with stall-free stretches.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic calm_out   = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 99) < 30) begin
        stall_left = pick_pause() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each result transaction is unpacked and compared field by field
  // with the oldest predicted result.
  // ---------------------------------------------------------------------------
  filter_result_t got;
  filter_result_t want;
  int             results_seen = 0;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind         = kind_t'(out_tuser);
      got.char_out     = out_tdata[7:0];
      got.wont         = out_tdata[8];
      got.opt          = out_tdata[16:9];
      got.cols         = out_tdata[32:17];
      got.rows         = out_tdata[48:33];
      got.none_kept    = out_tdata[49];
      got.last_of_byte = out_tlast;
      kind_seen[out_tuser]++;
      if (pending_results.size() == 0) begin
        record_failure($sformatf("result %0d arrived with nothing predicted (kind %0d)",
                                 results_seen, out_tuser));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.char_out !== want.char_out ||
            got.wont !== want.wont || got.opt !== want.opt ||
            got.cols !== want.cols || got.rows !== want.rows ||
            got.last_of_byte !== want.last_of_byte || got.none_kept !== want.none_kept)
          record_failure({
            $sformatf("result %0d: expected kind=%0d byte=%02h wont=%0b opt=%02h ",
                      results_seen, want.kind, want.char_out, want.wont, want.opt),
            $sformatf("w=%0d h=%0d last=%0b all_sw=%0b, ",
                      want.cols, want.rows, want.last_of_byte, want.none_kept),
            $sformatf("got kind=%0d byte=%02h wont=%0b opt=%02h ",
                      got.kind, got.char_out, got.wont, got.opt),
            $sformatf("w=%0d h=%0d last=%0b all_sw=%0b",
                      got.cols, got.rows, got.last_of_byte, got.none_kept)});
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results still predicted",
               IDLE_LIMIT, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed cases, then random telnet traffic, then drain.
  // ---------------------------------------------------------------------------
  int   pick;
  int   n;
  int   k;
  logic did_long = 1'b0;
  logic did_full = 1'b0;

  initial begin
    for (k = 0; k < 8; k++) kind_seen[k] = 0;

    // Short window size right after reset reads the cleared store.
    put_sb_open(OPT_NAWS);
    put_sb_close();
    // Data extremes, a doubled escape in data and an are-you-there.
    put_byte(8'h00);
    put_byte(8'hFE);
    put_byte(TN_IAC);
    put_byte(TN_IAC);
    put_byte(TN_IAC);
    put_byte(TN_AYT);
    // Refusals for WILL and DO, option 255, and a silent DONT.
    put_cmd(TN_WILL, 8'd5);
    put_cmd(TN_DO, 8'hFF);
    put_cmd(TN_DONT, 8'd9);
    // Full window size with a doubled escape inside the subnegotiation.
    put_sb_open(OPT_NAWS);
    put_escaped(8'hFF);
    put_escaped(8'h00);
    put_escaped(8'h00);
    put_escaped(8'd24);
    put_sb_close();
    // Terminal type with only two stored bytes, then a one-character name.
    put_sb_open(OPT_TTYPE);
    put_escaped(TTYPE_IS);
    put_sb_close();
    put_sb_open(OPT_TTYPE);
    put_escaped(TTYPE_IS);
    put_escaped(8'h76);
    put_sb_close();

    drain_next = 1'b1;
    while (rx_backlog.size() < TOTAL_BYTES) begin
      if (!did_long && rx_backlog.size() > 120) begin
        // Longest terminal-type name that fits the store.
        did_long   = 1'b1;
        drain_next = 1'b1;
        put_sb_open(OPT_TTYPE);
        put_escaped(TTYPE_IS);
        for (k = 0; k < DEPTH - 3; k++) put_escaped(pick_name_char());
        put_sb_close();
      end else if (!did_full && rx_backlog.size() > 260) begin
        // Overfill the store: the byte that fills it passes as data.
        did_full   = 1'b1;
        drain_next = 1'b1;
        put_byte(TN_IAC);
        put_byte(TN_SB);
        for (k = 0; k < DEPTH; k++) put_escaped(8'($urandom_range(0, 255)));
        put_byte(8'h41);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) drain_next = 1'b1;
        if (pick < 22) begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) put_byte(8'($urandom_range(0, 254)));
        end else if (pick < 32) begin
          put_byte(TN_IAC);
          put_byte(8'($urandom_range(240, 255)));
        end else if (pick < 50) begin
          put_cmd(8'($urandom_range(TN_WILL, TN_DONT)), pick_option());
        end else if (pick < 64) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
          put_sb_open(OPT_NAWS);
          for (k = 0; k < n; k++) put_escaped(8'($urandom_range(0, 255)));
          put_sb_close();
        end else if (pick < 80) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
          put_sb_open(OPT_TTYPE);
          put_escaped(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : TTYPE_IS);
          for (k = 0; k < n; k++) put_escaped(pick_name_char());
          put_sb_close();
        end else if (pick < 92) begin
          // Raw noise, which may open commands or subnegotiations of its own.
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++) put_byte(8'($urandom_range(0, 255)));
        end else begin
          // Broken subnegotiation: unknown option and a stray escaped byte.
          put_sb_open(8'($urandom_range(0, 255)));
          n = $urandom_range(0, 3);
          for (k = 0; k < n; k++) put_escaped(8'($urandom_range(0, 255)));
          put_byte(TN_IAC);
          put_byte(8'($urandom_range(241, 254)));
          put_sb_close();
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every byte went in and every predicted result came out.
    do @(negedge clk);
    while (have_next || rx_backlog.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (pending_results.size() != 0)
      record_failure($sformatf("%0d predicted results never arrived",
                               pending_results.size()));

    $display("Sent %0d bytes and checked %0d results, %0d failures.",
             bytes_sent, results_seen, fail_count);
    $display({"Kinds: %0d data, %0d swallowed, %0d refusals, ",
              "%0d are-you-there, %0d resize, %0d name bytes."},
             kind_seen[KIND_DATA], kind_seen[KIND_SWALLOW], kind_seen[KIND_REFUSE],
             kind_seen[KIND_AYT], kind_seen[KIND_RESIZE], kind_seen[KIND_TTYPE]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tcf_pkg.sv
rtl/tcf_ram.sv
rtl/tcf_datapath.sv
rtl/tcf_ctrl.sv
rtl/telnet_command_filter_unit.sv
sim/tb_top.sv
